>>> rtl/jsv_pkg.sv
`default_nettype none

package jsv_pkg;

  localparam int MAX_NESTING = 64;
  localparam int LEVEL_W     = $clog2(MAX_NESTING + 1);

  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef enum logic [4:0] {
    PH_VALUE, PH_AFTER, PH_ARR_FIRST, PH_OBJ_FIRST, PH_OBJ_KEY, PH_COLON,
    PH_STR, PH_STR_ESC, PH_STR_HEX, PH_KSTR, PH_KSTR_ESC, PH_KSTR_HEX,
    PH_LIT_T, PH_LIT_F, PH_LIT_N,
    PH_NUM_SIGN, PH_NUM_INT, PH_NUM_DOT, PH_NUM_FRAC, PH_NUM_E,
    PH_NUM_ESIGN, PH_NUM_EXP
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_VALID   = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  typedef enum logic {
    KIND_ARRAY  = 1'b0,
    KIND_OBJECT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_doc;
  } req_t;

  typedef struct packed {
    verdict_t verdict;
    logic     last_result;
  } rsp_t;

  localparam logic [31:0] WORD_TRUE  = "true";
  localparam logic [39:0] WORD_FALSE = "false";
  localparam logic [31:0] WORD_NULL  = "null";

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_simple_escape(input logic [7:0] c);
    return (c == "\"") || (c == "\\") || (c == "/") || (c == "b") ||
           (c == "f") || (c == "n") || (c == "r") || (c == "t");
  endfunction

  function automatic logic [2:0] lit_len(input phase_t ph);
    return (ph == PH_LIT_F) ? 3'd5 : 3'd4;
  endfunction

  // Expected letter of a literal; a position past the end gives zero, which
  // never matches because a zero byte does not reach the byte machine.
  function automatic logic [7:0] lit_char(input phase_t ph, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (ph)
      PH_LIT_T: if (idx < 3'd4) ch = WORD_TRUE[8*(3 - idx) +: 8];
      PH_LIT_F: if (idx < 3'd5) ch = WORD_FALSE[8*(4 - idx) +: 8];
      PH_LIT_N: if (idx < 3'd4) ch = WORD_NULL[8*(3 - idx) +: 8];
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/json_syntax_validator_unit.sv
// Each result is registered into the output buffer when its request is accepted.
// Throughput: one request per cycle; the parse state is updated in the cycle
// of acceptance and the result goes to a two-entry output buffer, so a request
// is taken whenever the second entry is free.
// Reset (rst, synchronous, active high) returns the parser to the start of a
// document, clears strict_mode and empties the output buffer.
`default_nettype none

module json_syntax_validator_unit
  import jsv_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       cfg_write,
  input  wire       cfg_data,
  input  wire       req_valid,
  output logic      req_ready,
  input  wire req_t req_data,
  output logic      rsp_valid,
  input  wire       rsp_ready,
  output rsp_t      rsp_data
);

  logic strict_mode;

  phase_t                 phase, phase_next;
  logic [MAX_NESTING-1:0] stack, stack_next;
  logic [LEVEL_W-1:0]     level, level_next;
  logic [2:0]             lit, lit_next;
  logic [2:0]             hex_left, hex_left_next;
  logic                   lz, lz_next;
  logic                   err, err_next;
  logic                   term, term_next;

  logic   accept;
  logic   [7:0] c;
  logic   top;
  logic   nest_full;

  // Byte machine results before the end-of-text check.
  phase_t             feed_phase;
  logic [2:0]         feed_lit, feed_hex;
  logic               feed_lz, feed_err;
  logic               push_en, pop_en;
  kind_t              push_kind;
  logic [2:0]         hex_dec;
  logic               fin, fin_bad;
  logic [LEVEL_W-1:0] level_fed;

  // Decision for a byte that follows a complete value.
  logic   av_fail, av_pop, av_comma;
  phase_t av_phase;

  // Decision for a byte that starts a value.
  logic   sv_fail, sv_push, sv_lz, sv_lit;
  phase_t sv_phase;
  kind_t  sv_kind;

  rsp_t result;
  logic skid_valid;
  rsp_t skid_data;

  assign accept    = req_valid && req_ready;
  assign req_ready = !skid_valid;
  assign c         = req_data.data_byte;
  assign top       = stack[0];
  assign nest_full = level >= LEVEL_W'(MAX_NESTING);

  always_comb begin
    av_fail  = 1'b0;
    av_pop   = 1'b0;
    av_comma = 1'b0;
    av_phase = PH_VALUE;
    if (!is_ws(c)) begin
      if (level == '0 || level > LEVEL_W'(MAX_NESTING)) begin
        av_fail = 1'b1;
      end else if (top == KIND_ARRAY && c == "]") begin
        av_pop = 1'b1;
      end else if (top == KIND_OBJECT && c == "}") begin
        av_pop = 1'b1;
      end else if (c == ",") begin
        av_comma = 1'b1;
        av_phase = (top == KIND_OBJECT) ? PH_OBJ_KEY : PH_VALUE;
      end else begin
        av_fail = 1'b1;
      end
    end
  end

  always_comb begin
    sv_fail  = 1'b0;
    sv_push  = 1'b0;
    sv_lz    = lz;
    sv_lit   = 1'b0;
    sv_kind  = KIND_ARRAY;
    sv_phase = phase;
    if (nest_full) begin
      sv_fail = 1'b1;
    end else if (c == "\"") begin
      sv_phase = PH_STR;
    end else if (c == "[") begin
      sv_push  = 1'b1;
      sv_phase = PH_ARR_FIRST;
    end else if (c == "{") begin
      sv_push  = 1'b1;
      sv_kind  = KIND_OBJECT;
      sv_phase = PH_OBJ_FIRST;
    end else if (c == "t") begin
      sv_phase = PH_LIT_T;
      sv_lit   = 1'b1;
    end else if (c == "f") begin
      sv_phase = PH_LIT_F;
      sv_lit   = 1'b1;
    end else if (c == "n") begin
      sv_phase = PH_LIT_N;
      sv_lit   = 1'b1;
    end else if (c == "-") begin
      sv_phase = PH_NUM_SIGN;
    end else if (is_digit(c)) begin
      sv_phase = PH_NUM_INT;
      sv_lz    = (c == "0");
    end else begin
      sv_fail = 1'b1;
    end
  end

  // Byte machine: one step per accepted byte.
  always_comb begin
    feed_phase = phase;
    feed_lit   = lit;
    feed_hex   = hex_left;
    feed_lz    = lz;
    feed_err   = err;
    push_en    = 1'b0;
    pop_en     = 1'b0;
    push_kind  = KIND_ARRAY;
    hex_dec    = (hex_left != 3'd0) ? hex_left - 3'd1 : hex_left;
    if (!term && c != 8'h00 && !err) begin
      case (phase)
        PH_VALUE, PH_ARR_FIRST: begin
          if (is_ws(c)) begin
          end else if (phase == PH_ARR_FIRST && c == "]") begin
            pop_en     = 1'b1;
            feed_phase = PH_AFTER;
          end else begin
            feed_err   = sv_fail;
            feed_phase = sv_phase;
            feed_lz    = sv_lz;
            push_en    = sv_push;
            push_kind  = sv_kind;
            if (sv_lit) feed_lit = 3'd1;
          end
        end
        PH_AFTER: begin
          feed_err = av_fail;
          pop_en   = av_pop;
          if (av_comma) feed_phase = av_phase;
        end
        PH_OBJ_FIRST: begin
          if (is_ws(c)) begin
          end else if (c == "}") begin
            pop_en     = 1'b1;
            feed_phase = PH_AFTER;
          end else if (c == "\"") begin
            feed_phase = PH_KSTR;
          end else begin
            feed_err = 1'b1;
          end
        end
        PH_OBJ_KEY: begin
          if (is_ws(c)) begin
          end else if (c == "\"") begin
            feed_phase = PH_KSTR;
          end else begin
            feed_err = 1'b1;
          end
        end
        PH_COLON: begin
          if (is_ws(c)) begin
          end else if (c == ":") begin
            feed_phase = PH_VALUE;
          end else begin
            feed_err = 1'b1;
          end
        end
        PH_STR, PH_KSTR: begin
          if (c == "\"") begin
            feed_phase = (phase == PH_KSTR) ? PH_COLON : PH_AFTER;
          end else if (strict_mode && c < CTRL_LIMIT) begin
            feed_err = 1'b1;
          end else if (c == "\\") begin
            feed_phase = (phase == PH_KSTR) ? PH_KSTR_ESC : PH_STR_ESC;
          end
        end
        PH_STR_ESC, PH_KSTR_ESC: begin
          if (c == "u") begin
            feed_phase = (phase == PH_KSTR_ESC) ? PH_KSTR_HEX : PH_STR_HEX;
            feed_hex   = 3'd4;
          end else if (is_simple_escape(c)) begin
            feed_phase = (phase == PH_KSTR_ESC) ? PH_KSTR : PH_STR;
          end else begin
            feed_err = 1'b1;
          end
        end
        PH_STR_HEX, PH_KSTR_HEX: begin
          if (!is_hex(c)) begin
            feed_err = 1'b1;
          end else begin
            feed_hex = hex_dec;
            if (hex_dec == 3'd0) begin
              feed_phase = (phase == PH_KSTR_HEX) ? PH_KSTR : PH_STR;
            end
          end
        end
        PH_LIT_T, PH_LIT_F, PH_LIT_N: begin
          if (lit_char(phase, lit) != c) begin
            feed_err = 1'b1;
          end else if (lit + 3'd1 == lit_len(phase)) begin
            feed_phase = PH_AFTER;
            feed_lit   = 3'd0;
          end else begin
            feed_lit = lit + 3'd1;
          end
        end
        PH_NUM_SIGN: begin
          if (is_digit(c)) begin
            feed_phase = PH_NUM_INT;
            feed_lz    = (c == "0");
          end else begin
            feed_err = 1'b1;
          end
        end
        PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP: begin
          if (is_digit(c)) begin
            if (phase == PH_NUM_INT && lz) feed_err = 1'b1;
          end else if (c == "." && phase == PH_NUM_INT) begin
            feed_phase = PH_NUM_DOT;
          end else if ((c == "e" || c == "E") && phase != PH_NUM_EXP) begin
            feed_phase = PH_NUM_E;
          end else begin
            // The number ends here and the byte is taken as one after a value.
            feed_phase = av_comma ? av_phase : PH_AFTER;
            feed_err   = av_fail;
            pop_en     = av_pop;
          end
        end
        PH_NUM_DOT: begin
          if (is_digit(c)) feed_phase = PH_NUM_FRAC;
          else feed_err = 1'b1;
        end
        PH_NUM_E: begin
          if (c == "+" || c == "-") feed_phase = PH_NUM_ESIGN;
          else if (is_digit(c)) feed_phase = PH_NUM_EXP;
          else feed_err = 1'b1;
        end
        PH_NUM_ESIGN: begin
          if (is_digit(c)) feed_phase = PH_NUM_EXP;
          else feed_err = 1'b1;
        end
        default: feed_err = 1'b1;
      endcase
    end
  end

  always_comb begin
    level_fed = level;
    if (push_en) level_fed = level + LEVEL_W'(1);
    else if (pop_en) level_fed = level - LEVEL_W'(1);
  end

  // End-of-text check and document clear.
  always_comb begin
    fin     = !term && (c == 8'h00 || req_data.end_of_doc);
    fin_bad = !(feed_phase == PH_AFTER || feed_phase == PH_NUM_INT ||
                feed_phase == PH_NUM_FRAC || feed_phase == PH_NUM_EXP) ||
              (level_fed != '0);
    err_next   = feed_err || (fin && fin_bad);
    phase_next = feed_phase;
    level_next = level_fed;
    lit_next   = feed_lit;
    hex_left_next = feed_hex;
    lz_next    = feed_lz;
    term_next  = term || fin;
    stack_next = stack;
    if (push_en) stack_next = MAX_NESTING'({stack, push_kind});
    else if (pop_en) stack_next = stack >> 1;
    if (req_data.end_of_doc) begin
      phase_next    = PH_VALUE;
      level_next    = '0;
      lit_next      = 3'd0;
      hex_left_next = 3'd0;
      lz_next       = 1'b0;
      term_next     = 1'b0;
    end
  end

  always_comb begin
    result.last_result = req_data.end_of_doc;
    if (err_next) result.verdict = VERDICT_INVALID;
    else if (req_data.end_of_doc) result.verdict = VERDICT_VALID;
    else result.verdict = VERDICT_PENDING;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
      phase       <= PH_VALUE;
      level       <= '0;
      lit         <= 3'd0;
      hex_left    <= 3'd0;
      lz          <= 1'b0;
      err         <= 1'b0;
      term        <= 1'b0;
    end else begin
      if (cfg_write) strict_mode <= cfg_data;
      if (accept) begin
        phase    <= phase_next;
        level    <= level_next;
        lit      <= lit_next;
        hex_left <= hex_left_next;
        lz       <= lz_next;
        err      <= err_next && !req_data.end_of_doc;
        term     <= term_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stack <= stack_next;
  end

  // Two-entry output buffer: the second entry takes a result while the first
  // one is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_valid && !rsp_ready) begin
      if (accept) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      rsp_valid  <= 1'b1;
      skid_valid <= accept;
    end else begin
      rsp_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && !rsp_ready) begin
      if (accept) skid_data <= result;
    end else if (skid_valid) begin
      rsp_data <= skid_data;
      if (accept) skid_data <= result;
    end else if (accept) begin
      rsp_data <= result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jsv_checker.sv
`default_nettype none

module jsv_checker
  import jsv_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       cfg_write,
  input wire       cfg_data,
  input wire       req_valid,
  input wire       req_ready,
  input wire req_t req_data,
  input wire       rsp_valid,
  input wire       rsp_ready,
  input wire rsp_t rsp_data
);

  // A stalled result stays in place.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // Requests are refused only while a result is waiting.
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("request refused with no result pending");

  // The result that closes a document carries a final verdict.
  a_final_verdict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.last_result |-> rsp_data.verdict != VERDICT_PENDING)
    else $error("closing result without a final verdict");

  // Reset leaves the output empty and the block ready.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("output not empty after reset");

endmodule

bind json_syntax_validator_unit jsv_checker u_jsv_checker (.*);

`default_nettype wire
